### hdl/signed_sketch_counter_update_assert.svh
// Assertion macros used by the checker of this block.
`ifndef SIGNED_SKETCH_COUNTER_UPDATE_ASSERT_SVH
`define SIGNED_SKETCH_COUNTER_UPDATE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SSC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/ssc_pkg.sv
package ssc_pkg;

    localparam int GROUPS_DEF       = 4096;
    localparam int COUNTER_BITS_DEF = 6;
    localparam int HASHES_DEF       = 3;

    localparam int WORD_BITS = 64;
    localparam int CFG_W     = 13;
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(4096);

    localparam logic [31:0] SEED_GROUP = 32'd1;
    localparam logic [31:0] SEED_SIGN  = 32'd2000;
    localparam logic [31:0] SEED_INDEX = 32'd1999;

    localparam logic [31:0] MM_C1 = 32'hcc9e2d51;
    localparam logic [31:0] MM_C2 = 32'h1b873593;
    localparam logic [31:0] MM_E  = 32'he6546b64;
    localparam logic [31:0] MM_F1 = 32'h85ebca6b;
    localparam logic [31:0] MM_F2 = 32'hc2b2ae35;
    localparam logic [31:0] MM_LEN = 32'd4;

    // Quotient bits retired per cycle by the remainder unit.
    localparam int REM_STEP = 4;

    typedef enum logic [1:0] {
        ACT_INC     = 2'd0,
        ACT_DEC     = 2'd1,
        ACT_SAT     = 2'd2,
        ACT_PROMOTE = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PMOD,
        ST_HASH,
        ST_HASH_W,
        ST_REM_W,
        ST_READ,
        ST_EVAL
    } t_state;

    typedef struct packed {
        logic [31:0] packet_number;
        logic [31:0] source_label;
        logic [31:0] dest_label;
    } t_in_item;

    typedef struct packed {
        t_action     action;
        logic [31:0] promoted_source;
        logic [31:0] promoted_dest;
    } t_out_item;

    typedef struct packed {
        logic        vld;
        logic [31:0] key;
        logic [31:0] seed;
    } t_hash_req;

    typedef struct packed {
        logic        vld;
        logic [31:0] hash;
    } t_hash_rsp;

    typedef struct packed {
        logic             start;
        logic [31:0]      dividend;
        logic [CFG_W-1:0] divisor;
    } t_rem_req;

    typedef struct packed {
        logic             done;
        logic [CFG_W-1:0] rem;
    } t_rem_rsp;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int r);
        return (x << r) | (x >> (32 - r));
    endfunction

endpackage

### hdl/ssc_ram.sv
module ssc_ram #(
    parameter int WIDTH = 60,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/ssc_hash.sv
// Pipelined 32-bit murmur hash of one four-byte key, at most one multiply per stage.
module ssc_hash
    import ssc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_hash_req i_req,
    output t_hash_rsp o_rsp
);

    logic [5:0]  r_vld;
    logic [31:0] r_k1, r_k2, r_h2, r_h3, r_h4, r_h5;
    logic [31:0] r_seed0, r_seed1;
    logic [31:0] w_h;

    always_comb begin
        w_h = r_seed1 ^ r_k2;
        w_h = rotl32(w_h, 13);
        w_h = (w_h << 2) + w_h + MM_E;
        w_h = w_h ^ MM_LEN;
        w_h = w_h ^ (w_h >> 16);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[4:0], i_req.vld};
        end
        r_k1    <= i_req.key * MM_C1;
        r_seed0 <= i_req.seed;
        r_k2    <= rotl32(r_k1, 15) * MM_C2;
        r_seed1 <= r_seed0;
        r_h2    <= w_h;
        r_h3    <= r_h2 * MM_F1;
        r_h4    <= (r_h3 ^ (r_h3 >> 13)) * MM_F2;
        r_h5    <= r_h4 ^ (r_h4 >> 16);
    end

    assign o_rsp.vld  = r_vld[5];
    assign o_rsp.hash = r_h5;

endmodule

### hdl/ssc_rem.sv
// Restoring remainder of a 32-bit value by a nonzero divisor, REM_STEP bits per cycle.
module ssc_rem
    import ssc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_rem_req i_req,
    output t_rem_rsp o_rsp
);

    localparam int NCYC = 32 / REM_STEP;
    localparam int CW   = $clog2(NCYC + 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [31:0]      r_num, n_num;
    logic [CFG_W-1:0] r_div, n_div;
    logic [CFG_W-1:0] r_rem, n_rem;
    logic [CFG_W:0]   w_t;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_div  = r_div;
        n_rem  = r_rem;
        w_t    = '0;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(NCYC);
            n_num  = i_req.dividend;
            n_div  = i_req.divisor;
            n_rem  = '0;
        end else if (r_busy) begin
            for (int s = 0; s < REM_STEP; s++) begin
                w_t = {n_rem, n_num[31]};
                n_num = {n_num[30:0], 1'b0};
                if (w_t >= {1'b0, r_div}) begin
                    w_t = w_t - {1'b0, r_div};
                end
                n_rem = w_t[CFG_W-1:0];
            end
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_num <= n_num;
        r_div <= n_div;
        r_rem <= n_rem;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

### hdl/signed_sketch_counter_update.sv
// Signed count-sketch counter update.
// Input channel (i_in_valid/o_in_ready) takes one packet beat: packet number,
// source label and destination label. Output channel (o_out_valid/i_out_ready)
// returns exactly one result beat per packet: the action and, on promotion,
// the two labels. The config channel (i_cfg_valid/o_cfg_ready) writes the
// group count and is always ready; write it only while the block is idle.
// One packet is processed at a time. A shared six-stage hash pipeline runs once
// per seed. The group remainder uses a serial unit retiring four bits per cycle;
// the step select (packet number modulo the hash count) and the counter indexes
// use a reciprocal multiply. Then the counter word is read and, unless the
// counter is saturated, updated and written back; the block then returns to idle.
// After reset the block sweeps the counter memory to zero, one word per cycle,
// over all GROUPS words (4096 by default), with o_in_ready low. The result sits
// in an output register; the next packet is accepted while it waits, but that
// packet's result is held back until the receiver takes the earlier one.
module signed_sketch_counter_update
    import ssc_pkg::*;
#(
    parameter int GROUPS       = GROUPS_DEF,
    parameter int COUNTER_BITS = COUNTER_BITS_DEF,
    parameter int HASHES       = HASHES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_item,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int PER_WORD = WORD_BITS / COUNTER_BITS;
    localparam int WW       = PER_WORD * COUNTER_BITS;
    localparam int AW       = $clog2(GROUPS);
    localparam int KW       = $clog2(PER_WORD);
    localparam int JW       = $clog2(HASHES + 2);
    localparam int SW       = (HASHES > 1) ? $clog2(HASHES) : 1;
    localparam int VW       = $clog2(HASHES + 1);
    localparam int HL       = $clog2(HASHES);
    localparam int PL       = $clog2(PER_WORD);
    localparam logic signed [COUNTER_BITS-1:0] CNT_MAX = {1'b0, {(COUNTER_BITS-1){1'b1}}};
    localparam logic signed [COUNTER_BITS-1:0] CNT_MIN = {1'b1, {(COUNTER_BITS-1){1'b0}}};
    // Rounded-up reciprocals; the quotient of any 32-bit value comes out exact.
    localparam logic [32:0] RCP_HASH =
        33'(((64'd1 << (32 + HL)) + 64'(HASHES - 1)) / 64'(HASHES));
    localparam logic [32:0] RCP_WORD =
        33'(((64'd1 << (32 + PL)) + 64'(PER_WORD - 1)) / 64'(PER_WORD));

    t_state           r_state, n_state;
    logic [CFG_W-1:0] r_group_count;
    t_in_item         r_item, n_item;
    logic [JW-1:0]    r_j, n_j;
    logic [SW-1:0]    r_hsel, n_hsel;
    logic [AW-1:0]    r_group, n_group;
    logic             r_up, n_up;
    logic [KW-1:0]    r_kidx [HASHES];
    logic [KW-1:0]    n_kidx [HASHES];
    logic [AW-1:0]    r_clr_addr, n_clr_addr;
    logic             r_out_v, n_out_v;
    t_out_item        r_out, n_out;

    logic             r_cm_done;
    logic             r_cm_sel;
    logic [31:0]      r_cm_x;
    logic [64:0]      r_cm_prod;
    logic             w_cm_start;
    logic             w_cm_sel;
    logic [31:0]      w_cm_x;
    logic [31:0]      w_cm_quo;
    logic [31:0]      w_cm_rem;

    t_hash_req        w_hreq;
    t_hash_rsp        w_hrsp;
    t_rem_req         w_rreq;
    t_rem_rsp         w_rrsp;
    logic [CFG_W-1:0] w_groups;

    logic             w_wr_en;
    logic [AW-1:0]    w_wr_addr;
    logic [WW-1:0]    w_wr_data;
    logic             w_rd_en;
    logic [WW-1:0]    w_rd_data;

    logic [KW-1:0]                  w_kstep;
    logic signed [COUNTER_BITS-1:0] w_cur;
    logic signed [COUNTER_BITS-1:0] w_v;
    logic [VW-1:0]                  w_votes;
    logic [WW-1:0]                  w_new_word;
    logic [31:0]                    w_seed;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_count <= CFG_RESET;
        end else if (i_cfg_valid) begin
            r_group_count <= i_cfg_data;
        end
    end

    // Zero selects one group; values above the memory depth use the whole memory.
    always_comb begin
        if (r_group_count == '0) begin
            w_groups = CFG_W'(1);
        end else if (32'(r_group_count) > 32'(GROUPS)) begin
            w_groups = CFG_W'(GROUPS);
        end else begin
            w_groups = r_group_count;
        end
    end

    ssc_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_hreq),
        .o_rsp   (w_hrsp)
    );

    ssc_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_rreq),
        .o_rsp   (w_rrsp)
    );

    ssc_ram #(
        .WIDTH (WW),
        .DEPTH (GROUPS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_group),
        .o_rd_data (w_rd_data)
    );

    // Remainder by the hash count or by the counters per word: the product is
    // registered, and the remainder is ready the cycle after the start.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cm_done <= 1'b0;
        end else begin
            r_cm_done <= w_cm_start;
        end
        if (w_cm_start) begin
            r_cm_x    <= w_cm_x;
            r_cm_sel  <= w_cm_sel;
            r_cm_prod <= 65'(w_cm_x) * 65'(w_cm_sel ? RCP_WORD : RCP_HASH);
        end
    end

    always_comb begin
        if (r_cm_sel) begin
            w_cm_quo = 32'(r_cm_prod >> (32 + PL));
            w_cm_rem = r_cm_x - w_cm_quo * 32'(PER_WORD);
        end else begin
            w_cm_quo = 32'(r_cm_prod >> (32 + HL));
            w_cm_rem = r_cm_x - w_cm_quo * 32'(HASHES);
        end
    end

    always_comb begin
        if (r_j == JW'(0)) begin
            w_seed = SEED_GROUP;
        end else if (r_j == JW'(1)) begin
            w_seed = SEED_SIGN;
        end else begin
            w_seed = SEED_INDEX + 32'(r_j) - 32'd2;
        end
    end

    // Step and vote over the word that was just read.
    always_comb begin
        w_kstep    = r_kidx[r_hsel];
        w_cur      = w_rd_data[w_kstep*COUNTER_BITS +: COUNTER_BITS];
        w_votes    = '0;
        w_new_word = w_rd_data;
        for (int i = 0; i < HASHES; i++) begin
            w_v = w_rd_data[r_kidx[i]*COUNTER_BITS +: COUNTER_BITS];
            if ((r_up && w_v == CNT_MAX) || (!r_up && w_v == CNT_MIN)) begin
                w_votes = w_votes + VW'(1);
            end
        end
        if (r_up) begin
            w_new_word[w_kstep*COUNTER_BITS +: COUNTER_BITS] = w_cur + COUNTER_BITS'(1);
        end else begin
            w_new_word[w_kstep*COUNTER_BITS +: COUNTER_BITS] = w_cur - COUNTER_BITS'(1);
        end
    end

    always_comb begin
        n_state    = r_state;
        n_item     = r_item;
        n_j        = r_j;
        n_hsel     = r_hsel;
        n_group    = r_group;
        n_up       = r_up;
        n_kidx     = r_kidx;
        n_clr_addr = r_clr_addr;
        n_out_v    = r_out_v && !i_out_ready;
        n_out      = r_out;
        o_in_ready = 1'b0;
        w_hreq     = '0;
        w_rreq     = '0;
        w_cm_start = 1'b0;
        w_cm_sel   = 1'b0;
        w_cm_x     = '0;
        w_rd_en    = 1'b0;
        w_wr_en    = 1'b0;
        w_wr_addr  = r_group;
        w_wr_data  = w_new_word;

        case (r_state)
            ST_CLEAR: begin
                w_wr_en    = 1'b1;
                w_wr_addr  = r_clr_addr;
                w_wr_data  = '0;
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(GROUPS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_item     = i_in_item;
                    w_cm_start = 1'b1;
                    w_cm_sel   = 1'b0;
                    w_cm_x     = i_in_item.packet_number;
                    n_state    = ST_PMOD;
                end
            end
            ST_PMOD: begin
                if (r_cm_done) begin
                    n_hsel  = SW'(w_cm_rem);
                    n_j     = '0;
                    n_state = ST_HASH;
                end
            end
            ST_HASH: begin
                w_hreq.vld  = 1'b1;
                w_hreq.key  = r_item.source_label;
                w_hreq.seed = w_seed;
                n_state     = ST_HASH_W;
            end
            ST_HASH_W: begin
                if (w_hrsp.vld) begin
                    if (r_j == JW'(1)) begin
                        n_up    = !w_hrsp.hash[0];
                        n_j     = r_j + JW'(1);
                        n_state = ST_HASH;
                    end else if (r_j == JW'(0)) begin
                        w_rreq.start    = 1'b1;
                        w_rreq.dividend = w_hrsp.hash;
                        w_rreq.divisor  = w_groups;
                        n_state         = ST_REM_W;
                    end else begin
                        w_cm_start = 1'b1;
                        w_cm_sel   = 1'b1;
                        w_cm_x     = w_hrsp.hash;
                        n_state    = ST_REM_W;
                    end
                end
            end
            ST_REM_W: begin
                if (r_j == JW'(0)) begin
                    if (w_rrsp.done) begin
                        n_group = AW'(w_rrsp.rem);
                        n_j     = r_j + JW'(1);
                        n_state = ST_HASH;
                    end
                end else if (r_cm_done) begin
                    n_kidx[SW'(r_j - JW'(2))] = KW'(w_cm_rem);
                    if (r_j == JW'(HASHES + 1)) begin
                        n_state = ST_READ;
                    end else begin
                        n_j     = r_j + JW'(1);
                        n_state = ST_HASH;
                    end
                end
            end
            ST_READ: begin
                w_rd_en = 1'b1;
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                if (!r_out_v || i_out_ready) begin
                    n_out_v               = 1'b1;
                    n_out.promoted_source = '0;
                    n_out.promoted_dest   = '0;
                    if (r_up && w_cur != CNT_MAX) begin
                        w_wr_en      = 1'b1;
                        n_out.action = ACT_INC;
                    end else if (!r_up && w_cur != CNT_MIN) begin
                        w_wr_en      = 1'b1;
                        n_out.action = ACT_DEC;
                    end else if (32'(w_votes) >= 32'((HASHES + 1) / 2)) begin
                        n_out.action          = ACT_PROMOTE;
                        n_out.promoted_source = r_item.source_label;
                        n_out.promoted_dest   = r_item.dest_label;
                    end else begin
                        n_out.action = ACT_SAT;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_out_v    <= 1'b0;
            r_j        <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_out_v    <= n_out_v;
            r_j        <= n_j;
        end
        r_item  <= n_item;
        r_hsel  <= n_hsel;
        r_group <= n_group;
        r_up    <= n_up;
        r_kidx  <= n_kidx;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_v;
    assign o_out_item  = r_out;

endmodule

### hdl/ssc_checker.sv
`include "signed_sketch_counter_update_assert.svh"

module ssc_checker
    import ssc_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_ready,
    input t_in_item         i_in_item,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input t_out_item        o_out_item,
    input logic             i_cfg_valid,
    input logic             o_cfg_ready,
    input logic [CFG_W-1:0] i_cfg_data
);

    logic w_in_beat;
    logic w_labels_clear;

    assign w_in_beat      = i_in_valid && o_in_ready;
    assign w_labels_clear = (o_out_item.promoted_source == '0)
                         && (o_out_item.promoted_dest == '0);

    // Only one packet is in flight, so the input closes right after a beat.
    `SSC_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, w_in_beat, !o_in_ready, "input taken while busy")

    // A result never shows up just after a packet is taken.
    `SSC_ASSERT_NEXT(a_no_instant_result, i_clk, i_rst_n, w_in_beat, !$rose(o_out_valid), "result too early")

    `SSC_ASSERT_SAME(a_labels_only_on_promote, i_clk, i_rst_n, o_out_valid && (o_out_item.action != ACT_PROMOTE), w_labels_clear, "labels set without promotion")

    `SSC_ASSERT_NEXT(a_out_holds, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_item), "result dropped while stalled")

endmodule

bind signed_sketch_counter_update ssc_checker u_ssc_checker (.*);
